/* hdl/frame_energy_voice_detector_top_defines.svh */
// Assertion macros for the frame energy voice detector.
// Used by frame_energy_voice_detector_top; needs nothing else.
`ifndef FRAME_ENERGY_VOICE_DETECTOR_TOP_DEFINES_SVH
`define FRAME_ENERGY_VOICE_DETECTOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on aclk, off during reset
`define FEVD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fevd assertion failed");
// next-cycle implication, sampled on aclk, off during reset
`define FEVD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fevd assertion failed");
`else
`define FEVD_ASSERT_IMP(lbl, ante, cons)
`define FEVD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* hdl/fevd_pkg.sv */
// Shared types, widths and codes of the frame energy voice detector.
// No dependencies; imported by every module of the block.
package fevd_pkg;

    // sizing
    localparam int MAX_FRAME        = 4096;
    localparam int MAX_CALIB_FRAMES = 256;
    localparam int SAMPLE_W         = 16;
    localparam int CNT_W            = $clog2(MAX_FRAME + 1);
    localparam int AMP_SUM_W        = SAMPLE_W - 1 + CNT_W;
    localparam int LEVEL_W          = 24;
    localparam int DIVIDEND_W       = AMP_SUM_W + 8;
    localparam int DIVISOR_W        = CNT_W;
    localparam int QCNT_W           = $clog2(LEVEL_W + 1);
    localparam int CAL_CNT_W        = $clog2(MAX_CALIB_FRAMES + 1);
    localparam int CAL_SUM_W        = SAMPLE_W - 1 + CAL_CNT_W;
    localparam int CUT_W            = 26;
    localparam int WHOLE_W          = 17;
    localparam int LIMIT_W          = 8;
    localparam int CFG_IDX_W        = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_ADJUST = 1'b1;

    typedef enum logic [1:0] {
        KIND_DETECT = 2'd0,
        KIND_CALIB  = 2'd1,
        KIND_CLOSE  = 2'd2,
        KIND_UNUSED = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        RES_VERDICT = 2'd0,
        RES_CLOSED  = 2'd1,
        RES_ERROR   = 2'd2
    } result_kind_t;

    typedef enum logic [1:0] {
        OP_FRAME,
        OP_CLOSE,
        OP_ERROR
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic in_ready;
        logic accept;
        logic div_start;
        logic div_calib;
        logic commit;
        op_t  op;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic frame_end;
        logic calib_empty;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

/* hdl/fevd_divider.sv */
// Restoring divider, one quotient bit per cycle, LEVEL_W quotient bits per division.
// Depends on fevd_pkg. Caller guarantees the quotient fits in LEVEL_W bits.
module fevd_divider
    import fevd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [LEVEL_W-1:0]    quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [QCNT_W-1:0]    cnt_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] dvs_reg;
    logic [LEVEL_W-1:0]   quo_reg;

    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 ge;

    // trial subtract of the shifted remainder
    always_comb begin
        trial = {rem_reg, quo_reg[LEVEL_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = (trial >= {1'b0, dvs_reg});
    end

    // control: busy flag, bit counter, done pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= QCNT_W'(LEVEL_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == QCNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // data: high dividend bits seed the remainder, low bits shift through
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= DIVISOR_W'(dividend[DIVIDEND_W-1:LEVEL_W]);
            quo_reg <= dividend[LEVEL_W-1:0];
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[LEVEL_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hdl/fevd_datapath.sv */
// Datapath: frame accumulator, config registers, silence counter, calibration
// sums, shared divider and output register. Depends on fevd_pkg, fevd_divider.
module fevd_datapath
    import fevd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [SAMPLE_W-1:0]   cfg_wdata,
    input  logic [1:0]            s_kind,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    input  logic                  s_last_of_frame,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_result_kind,
    output logic                  m_voice,
    output logic [LEVEL_W-1:0]    m_frame_level,
    output logic signed [WHOLE_W-1:0] m_cutoff_whole
);

    logic [LIMIT_W-1:0]      limit_reg;
    logic [SAMPLE_W-1:0]     adjust_reg;
    logic [AMP_SUM_W-1:0]    amp_sum_reg;
    logic [CNT_W-1:0]        n_reg;
    logic                    frame_calib_reg;
    logic [LIMIT_W-1:0]      silence_reg;
    logic signed [CUT_W-1:0] cutoff_reg;
    logic [CAL_SUM_W-1:0]    cal_sum_reg;
    logic [CAL_CNT_W-1:0]    cal_frames_reg;
    logic                    m_valid_reg;
    logic [1:0]              rk_reg;
    logic                    voice_reg;
    logic [LEVEL_W-1:0]      level_reg;
    logic [WHOLE_W-1:0]      whole_reg;

    logic [SAMPLE_W-1:0]     abs_s;
    logic [CNT_W-1:0]        n_inc;
    logic [DIVIDEND_W-1:0]   dividend;
    logic [DIVISOR_W-1:0]    divisor;
    logic                    div_done;
    logic [LEVEL_W-1:0]      quotient;
    logic                    lt;
    logic                    gt;
    logic [LIMIT_W-1:0]      cnt_step;
    logic                    silent;
    logic [LIMIT_W-1:0]      cnt_final;
    logic signed [CUT_W-1:0] cut_new;
    logic [CUT_W-1:0]        cut_mag;
    logic [WHOLE_W-1:0]      whole_mag;
    logic [WHOLE_W-1:0]      whole_val;
    logic                    cal_room;

    // sample magnitude and frame-end detect (flag or frame length cap)
    always_comb begin
        abs_s = s_sample[SAMPLE_W-1] ? (~s_sample + 1'b1) : s_sample;
        n_inc = n_reg + 1'b1;
    end

    assign status.frame_end   = s_last_of_frame || (n_inc == CNT_W'(MAX_FRAME));
    assign status.calib_empty = (cal_frames_reg == '0);
    assign status.div_done    = div_done;
    assign status.out_free    = !m_valid_reg || m_ready;

    // divider operands: frame mean or calibration mean, both scaled by 256
    always_comb begin
        if (cmd.div_calib) begin
            dividend = DIVIDEND_W'({cal_sum_reg, 8'h00});
            divisor  = DIVISOR_W'(cal_frames_reg);
        end else begin
            dividend = {amp_sum_reg, 8'h00};
            divisor  = n_reg;
        end
    end

    fevd_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    // silence counter rule on the frame mean
    always_comb begin
        lt = $signed({2'b00, quotient}) < cutoff_reg;
        gt = $signed({2'b00, quotient}) > cutoff_reg;
        cnt_step = silence_reg;
        if (lt && (silence_reg != '1)) begin
            cnt_step = silence_reg + 1'b1;
        end else if (gt && (silence_reg != '0)) begin
            cnt_step = silence_reg - 1'b1;
        end
        silent    = (cnt_step == limit_reg);
        cnt_final = (silent && (cnt_step != '0)) ? (cnt_step - 1'b1) : cnt_step;
        cal_room  = frame_calib_reg && (cal_frames_reg < CAL_CNT_W'(MAX_CALIB_FRAMES));
    end

    // new cutoff and its whole part, truncated toward zero
    always_comb begin
        cut_new   = $signed({2'b00, quotient})
                  + $signed({{(CUT_W-SAMPLE_W-8){adjust_reg[SAMPLE_W-1]}}, adjust_reg, 8'h00});
        cut_mag   = cut_new[CUT_W-1] ? (~cut_new + 1'b1) : cut_new;
        whole_mag = WHOLE_W'(cut_mag[CUT_W-1:8]);
        whole_val = cut_new[CUT_W-1] ? (~whole_mag + 1'b1) : whole_mag;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg  <= LIMIT_W'(2);
            adjust_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SILENCE_LIMIT: limit_reg  <= cfg_wdata[LIMIT_W-1:0];
                CFG_CUTOFF_ADJUST: adjust_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // frame and detector state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amp_sum_reg     <= '0;
            n_reg           <= '0;
            frame_calib_reg <= 1'b0;
            silence_reg     <= '0;
            cutoff_reg      <= '0;
            cal_sum_reg     <= '0;
            cal_frames_reg  <= '0;
        end else if (cmd.accept) begin
            amp_sum_reg     <= amp_sum_reg + AMP_SUM_W'(abs_s);
            n_reg           <= n_inc;
            frame_calib_reg <= (kind_t'(s_kind) == KIND_CALIB);
        end else if (cmd.commit) begin
            case (cmd.op)
                OP_FRAME: begin
                    amp_sum_reg <= '0;
                    n_reg       <= '0;
                    silence_reg <= cnt_final;
                    if (cal_room) begin
                        cal_frames_reg <= cal_frames_reg + 1'b1;
                        if (!silent) begin
                            cal_sum_reg <= cal_sum_reg
                                         + CAL_SUM_W'(quotient[LEVEL_W-1:8]);
                        end
                    end
                end
                OP_CLOSE: begin
                    cutoff_reg     <= cut_new;
                    cal_sum_reg    <= '0;
                    cal_frames_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    // output register: holds a result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            case (cmd.op)
                OP_FRAME: begin
                    rk_reg    <= RES_VERDICT;
                    voice_reg <= !silent;
                    level_reg <= quotient;
                    whole_reg <= '0;
                end
                OP_CLOSE: begin
                    rk_reg    <= RES_CLOSED;
                    voice_reg <= 1'b0;
                    level_reg <= '0;
                    whole_reg <= whole_val;
                end
                default: begin
                    rk_reg    <= RES_ERROR;
                    voice_reg <= 1'b0;
                    level_reg <= '0;
                    whole_reg <= '0;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_kind  = rk_reg;
    assign m_voice        = voice_reg;
    assign m_frame_level  = level_reg;
    assign m_cutoff_whole = $signed(whole_reg);

endmodule

/* hdl/fevd_ctrl.sv */
// Controller FSM: sequences accumulate, divide and commit per request.
// Depends on fevd_pkg; talks to fevd_datapath through cmd_t / status_t.
module fevd_ctrl
    import fevd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [1:0] s_kind,
    input  status_t    status,
    output cmd_t       cmd
);

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    kind_t  kind;

    assign kind = kind_t'(s_kind);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_FRAME;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (kind)
                        KIND_DETECT, KIND_CALIB: begin
                            if (status.frame_end) begin
                                state_next = ST_LOAD;
                                op_next    = OP_FRAME;
                            end
                        end
                        KIND_CLOSE: begin
                            if (status.calib_empty) begin
                                state_next = ST_FINISH;
                                op_next    = OP_ERROR;
                            end else begin
                                state_next = ST_DIVIDE;
                                op_next    = OP_CLOSE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOAD:   state_next = ST_DIVIDE;
            ST_DIVIDE: if (status.div_done) state_next = ST_FINISH;
            ST_FINISH: if (status.out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd.in_ready  = 1'b0;
        cmd.accept    = 1'b0;
        cmd.div_start = 1'b0;
        cmd.div_calib = 1'b0;
        cmd.commit    = 1'b0;
        cmd.op        = op_reg;
        case (state_reg)
            ST_IDLE: begin
                cmd.in_ready = 1'b1;
                if (s_valid) begin
                    case (kind)
                        KIND_DETECT, KIND_CALIB: cmd.accept = 1'b1;
                        KIND_CLOSE: begin
                            cmd.div_calib = 1'b1;
                            cmd.div_start = !status.calib_empty;
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOAD:   cmd.div_start = 1'b1;
            ST_FINISH: cmd.commit    = status.out_free;
            default: ;
        endcase
    end

endmodule

/* hdl/frame_energy_voice_detector_top.sv */
// Top level of the frame energy voice detector.
// Depends on fevd_pkg, fevd_ctrl, fevd_datapath and the assertion header.
//
//  channel  direction  handshake           payload
//  s_       in         s_valid / s_ready   s_kind, s_sample, s_last_of_frame
//  m_       out        m_valid / m_ready   m_result_kind, m_voice,
//                                          m_frame_level, m_cutoff_whole
//  cfg_     in         cfg_wr_en           cfg_index, cfg_wdata
//
// A sample inside a frame is only accumulated. The last sample of a frame runs
// accept, divider load, 24 quotient bits, done and commit; a close request
// skips the load, and an error close goes straight from accept to commit.
// Reset is synchronous, active low; no clearing pass is needed.
// A result waits in the output register while the next samples are taken;
// the commit of a further result stalls until that register is free.
`include "frame_energy_voice_detector_top_defines.svh"

module frame_energy_voice_detector_top
    import fevd_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [SAMPLE_W-1:0]       cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_kind,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    input  logic                      s_last_of_frame,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_result_kind,
    output logic                      m_voice,
    output logic [LEVEL_W-1:0]        m_frame_level,
    output logic signed [WHOLE_W-1:0] m_cutoff_whole
);

    cmd_t    cmd;
    status_t status;

    fevd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_kind),
        .status  (status),
        .cmd     (cmd)
    );

    fevd_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_kind          (s_kind),
        .s_sample        (s_sample),
        .s_last_of_frame (s_last_of_frame),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_voice         (m_voice),
        .m_frame_level   (m_frame_level),
        .m_cutoff_whole  (m_cutoff_whole)
    );

    assign s_ready = cmd.in_ready;

    // a commit never overwrites a result still waiting
    `FEVD_ASSERT_IMP(a_commit_free, cmd.commit, status.out_free)
    // no request is taken while a division runs
    `FEVD_ASSERT_NXT(a_start_blocks, cmd.div_start, !s_ready)
    `FEVD_ASSERT_IMP(a_done_blocks, status.div_done, !s_ready)

endmodule

/* verif/frame_energy_voice_detector_top_tb.sv */
// Self-checking testbench for frame_energy_voice_detector_top: drives samples,
// frame marks and calibration closes, predicts every verdict and checks it.
// Depends on fevd_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module frame_energy_voice_detector_top_tb
    import fevd_pkg::*;
();

    localparam int SETTLE_CYCLES  = 40;    // longer than one frame-end division
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake or register write
    localparam int MAX_PRINTED    = 200;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;
    typedef enum {AMP_FULL, AMP_NEAR, AMP_QUIET} amp_t;

    // Predicts frame verdicts and calibration closes; checks results in order.
    class voice_scoreboard;
        typedef struct packed {
            result_kind_t              kind;
            logic                      voice;
            logic [LEVEL_W-1:0]        level;
            logic signed [WHOLE_W-1:0] whole;
        } verdict_t;

        bit [7:0]         silence_limit = 8'd2;
        bit signed [15:0] cutoff_adjust = '0;
        bit [28:0]        amp_sum;
        bit [12:0]        samples_in_frame;
        bit [7:0]         silence_count;
        bit signed [25:0] cutoff_level;
        bit [24:0]        calib_level_sum;
        bit [8:0]         calib_frames;
        verdict_t         pending_results[$];
        int               n_mismatch;

        task report(string what);
            n_mismatch++;
            if (n_mismatch <= MAX_PRINTED)
                $display("%0t mismatch: %s", $time, what);
        endtask

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] data);
            if (idx == CFG_SILENCE_LIMIT) begin
                silence_limit = data[7:0];
            end else begin
                cutoff_adjust = data;
            end
        endfunction

        // silence counter rule; returns 1 for voice
        function bit judge_frame(longint lvl);
            if (lvl < longint'(cutoff_level)) begin
                if (silence_count != 8'd255)
                    silence_count++;
            end else if (lvl > longint'(cutoff_level)) begin
                if (silence_count != 8'd0)
                    silence_count--;
            end
            if (silence_count == silence_limit) begin
                if (silence_count != 8'd0)
                    silence_count--;
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void take_request(kind_t kind, logic signed [SAMPLE_W-1:0] smp, logic last);
            longint   mag;
            longint   lvl;
            longint   cut;
            verdict_t v;
            v = '0;
            if (kind == KIND_UNUSED)
                return;
            // close: sum of voiced calibration levels over all calibration frames, plus the adjust
            if (kind == KIND_CLOSE) begin
                if (calib_frames == 0) begin
                    v.kind = RES_ERROR;
                end else begin
                    cut = longint'(calib_level_sum) * 256 / longint'(calib_frames)
                        + longint'(cutoff_adjust) * 256;
                    cutoff_level    = cut[25:0];
                    v.kind          = RES_CLOSED;
                    v.whole         = WHOLE_W'(cut / 256);
                    calib_level_sum = '0;
                    calib_frames    = '0;
                end
                pending_results.push_back(v);
                return;
            end
            // sample: accumulate, close the frame on last or on overlong
            mag = smp;
            if (mag < 0)
                mag = -mag;
            amp_sum += 29'(mag);
            samples_in_frame++;
            if (!last && samples_in_frame < MAX_FRAME)
                return;
            lvl = longint'(amp_sum) * 256 / longint'(samples_in_frame);
            amp_sum          = '0;
            samples_in_frame = '0;
            v.voice = judge_frame(lvl);
            if (kind == KIND_CALIB && calib_frames < MAX_CALIB_FRAMES) begin
                calib_frames++;
                if (v.voice)
                    calib_level_sum += 25'(lvl >> 8);
            end
            v.kind  = RES_VERDICT;
            v.level = LEVEL_W'(lvl);
            pending_results.push_back(v);
        endfunction

        task check_result(logic [1:0] rk, logic voice, logic [LEVEL_W-1:0] lvl,
                          logic signed [WHOLE_W-1:0] whole);
            verdict_t e;
            if (pending_results.size() == 0) begin
                report($sformatf("result kind %0d with nothing expected", rk));
                return;
            end
            e = pending_results.pop_front();
            if (rk !== e.kind)
                report($sformatf("result_kind %0d, expected %0d", rk, e.kind));
            if (voice !== e.voice)
                report($sformatf("voice %0b, expected %0b", voice, e.voice));
            if (lvl !== e.level)
                report($sformatf("frame_level %0d, expected %0d", lvl, e.level));
            if (whole !== e.whole)
                report($sformatf("cutoff_whole %0d, expected %0d", whole, e.whole));
        endtask

        function bit drained();
            return pending_results.size() == 0;
        endfunction

        function int cutoff_whole();
            return int'(longint'(cutoff_level) / 256);
        endfunction
    endclass

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_wr_en;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [SAMPLE_W-1:0]         cfg_wdata;
    logic                        s_valid;
    logic                        s_ready;
    logic [1:0]                  s_kind;
    logic signed [SAMPLE_W-1:0]  s_sample;
    logic                        s_last_of_frame;
    logic                        m_valid;
    logic                        m_ready;
    logic [1:0]                  m_result_kind;
    logic                        m_voice;
    logic [LEVEL_W-1:0]          m_frame_level;
    logic signed [WHOLE_W-1:0]   m_cutoff_whole;

    voice_scoreboard sb;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int stuck_cycles;

    frame_energy_voice_detector_top i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_sample        (s_sample),
        .s_last_of_frame (s_last_of_frame),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_voice         (m_voice),
        .m_frame_level   (m_frame_level),
        .m_cutoff_whole  (m_cutoff_whole)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // result side: random back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_result_kind, m_voice, m_frame_level, m_cutoff_whole);
    end

    // watchdog: any handshake or register write counts as progress
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("frame_energy_voice_detector_top_tb: errors");
                $finish;
            end
        end
    end

    // one request, with random idle cycles ahead of it
    task automatic send(kind_t kind, logic signed [SAMPLE_W-1:0] smp, logic last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_kind          <= kind;
        s_sample        <= smp;
        s_last_of_frame <= last;
        do @(posedge aclk); while (!s_ready);
        sb.take_request(kind, smp, last);
    endtask

    task automatic drain_results(int extra);
        s_valid <= 1'b0;
        do @(posedge aclk); while (!sb.drained());
        repeat (extra) @(posedge aclk);
    endtask

    // wait for the block to go idle, then load both registers
    task automatic begin_phase(logic [7:0] limit, logic signed [15:0] adjust, idling_t idling);
        drain_results(SETTLE_CYCLES);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SILENCE_LIMIT;
        cfg_wdata <= {8'h00, limit};
        @(posedge aclk);
        sb.write_reg(CFG_SILENCE_LIMIT, {8'h00, limit});
        cfg_index <= CFG_CUTOFF_ADJUST;
        cfg_wdata <= adjust;
        @(posedge aclk);
        sb.write_reg(CFG_CUTOFF_ADJUST, adjust);
        cfg_wr_en <= 1'b0;
        src_idle_pct   = (idling == IDLE_SENDER)   ? 79 : (idling == IDLE_BOTH) ? 27 : 0;
        sink_stall_pct = (idling == IDLE_RECEIVER) ? 79 : (idling == IDLE_BOTH) ? 27 : 0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] draw_sample(amp_t amp, int base);
        int mag;
        case (amp)
            AMP_FULL:  return $urandom_range(0, 65535);
            AMP_NEAR:  mag = base + int'($urandom_range(0, 64)) - 32;
            default:   mag = $urandom_range(0, 200);
        endcase
        if (mag < 0)
            mag = 0;
        if (mag > 32767)
            mag = 32767;
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    // frames of random length and content, with stray closes and unused kinds
    task automatic run_traffic(int n_items);
        int    sent;
        int    len;
        int    base;
        amp_t  amp;
        kind_t frame_kind;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 64) : $urandom_range(1, 6);
            frame_kind = $urandom_range(0, 1) ? KIND_CALIB : KIND_DETECT;
            amp = amp_t'($urandom_range(0, 2));
            base = sb.cutoff_whole();
            if (base < 0)
                base = 0;
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 99) < 4)
                    send(KIND_UNUSED, draw_sample(AMP_FULL, 0), $urandom_range(0, 1));
                if ($urandom_range(0, 99) < 3) begin
                    send(KIND_CLOSE, draw_sample(AMP_FULL, 0), $urandom_range(0, 1));
                    sent++;
                end
                if ($urandom_range(0, 299) == 0)
                    drain_results(0);
                send((i == len - 1) ? frame_kind : kind_t'($urandom_range(0, 1)),
                     draw_sample(amp, base), i == len - 1);
                sent++;
            end
            if ($urandom_range(0, 99) < 10) begin
                send(KIND_CLOSE, draw_sample(AMP_FULL, 0), $urandom_range(0, 1));
                sent++;
            end
        end
    endtask

    initial begin
        int lo;
        sb = new();
        aresetn         <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_index       <= CFG_SILENCE_LIMIT;
        cfg_wdata       <= '0;
        s_valid         <= 1'b0;
        s_kind          <= KIND_DETECT;
        s_sample        <= '0;
        s_last_of_frame <= 1'b0;
        m_ready         <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset registers, no idling
        send(KIND_CLOSE, 16'sd77, 1'b0);         // close with no frames
        send(KIND_DETECT, -16'sd32768, 1'b1);    // largest level
        send(KIND_DETECT, 16'sd32767, 1'b1);
        send(KIND_DETECT, 16'sd0, 1'b1);         // equal to cutoff
        send(KIND_DETECT, -16'sd1, 1'b1);
        send(KIND_UNUSED, 16'sd12345, 1'b1);     // ignored
        send(KIND_CALIB, 16'sd1234, 1'b0);
        send(KIND_UNUSED, -16'sd5, 1'b1);        // must not end the frame
        send(KIND_CLOSE, -16'sd9, 1'b1);         // close mid-frame, still empty
        send(KIND_DETECT, 16'sd100, 1'b1);       // detect frame, calib first sample
        send(KIND_DETECT, 16'sd500, 1'b0);
        send(KIND_CALIB, -16'sd700, 1'b1);       // calib frame, detect first sample
        send(KIND_CALIB, 16'sd32767, 1'b1);
        send(KIND_CALIB, -16'sd32768, 1'b1);
        send(KIND_CLOSE, 16'sd0, 1'b0);
        send(KIND_CLOSE, 16'sd0, 1'b0);          // nothing left to close
        send(KIND_DETECT, 16'sd1, 1'b1);
        send(KIND_DETECT, 16'sd0, 1'b1);         // below cutoff: counter climbs
        send(KIND_DETECT, 16'sd0, 1'b1);
        send(KIND_DETECT, 16'sd0, 1'b1);
        send(KIND_CALIB, 16'sd0, 1'b1);
        send(KIND_DETECT, 16'sd32767, 1'b1);

        begin_phase(8'd1, -16'sd32768, IDLE_SENDER);
        run_traffic(100);
        begin_phase(8'd255, 16'sd32767, IDLE_RECEIVER);
        run_traffic(100);
        begin_phase(8'd3, 16'sd40, IDLE_BOTH);
        run_traffic(100);

        // more calibration frames than the counter takes
        begin_phase($urandom_range(1, 8), $urandom_range(0, 3000) - 1500, IDLE_NONE);
        for (int i = 0; i < 260; i++)
            send(KIND_CALIB, draw_sample(AMP_FULL, 0), 1'b1);
        send(KIND_CLOSE, draw_sample(AMP_FULL, 0), 1'b1);

        // short traffic under fresh random registers
        begin_phase($urandom_range(1, 8), $urandom_range(0, 3000) - 1500, IDLE_NONE);
        run_traffic(50);

        // long silence: counter up to the top of its range
        begin_phase(8'd255, 16'sd1000, IDLE_RECEIVER);
        send(KIND_CLOSE, draw_sample(AMP_FULL, 0), $urandom_range(0, 1));
        for (int i = 0; i < 3; i++)
            send(KIND_CALIB, draw_sample(AMP_QUIET, 0), 1'b1);
        send(KIND_CLOSE, draw_sample(AMP_FULL, 0), $urandom_range(0, 1));
        for (int i = 0; i < 256; i++)
            send(KIND_DETECT, draw_sample(AMP_QUIET, 0), 1'b1);

        // limit below the counter: counter saturates
        begin_phase(8'd1, 16'sd1000, IDLE_NONE);
        for (int i = 0; i < 10; i++)
            send(KIND_DETECT, draw_sample(AMP_QUIET, 0), 1'b1);

        // limit of zero: loud frames walk the counter down to zero and hold it
        begin_phase(8'd0, 16'sd1000, IDLE_SENDER);
        lo = sb.cutoff_whole() + 1;
        if (lo < 0)
            lo = 0;
        if (lo > 32767)
            lo = 32767;
        for (int i = 0; i < 270; i++)
            send(KIND_DETECT, ($urandom_range(0, 1) ? -1 : 1) * int'($urandom_range(lo, 32767)),
                 1'b1);

        for (int ph = 0; ph < 4; ph++) begin
            begin_phase(($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 6),
                        ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                    : $urandom_range(0, 3000) - 1500,
                        idling_t'(ph));
            run_traffic(60);
        end

        drain_results(SETTLE_CYCLES);
        if (sb.n_mismatch == 0) begin
            $display("frame_energy_voice_detector_top_tb: clean");
        end else begin
            $display("frame_energy_voice_detector_top_tb: errors");
        end
        $finish;
    end

endmodule
